/* rtl/core/looping_sample_voice_assert.svh */
// ----------------------------------------------------------------------------
// looping_sample_voice assertion macros
// Clocked, reset-qualified property checks for the voice RTL.
// ----------------------------------------------------------------------------
`ifndef LOOPING_SAMPLE_VOICE_ASSERT_SVH
`define LOOPING_SAMPLE_VOICE_ASSERT_SVH

// implication check sampled on aclk, off during reset
`define LSV_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check sampled on aclk, off during reset
`define LSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lsv_pkg.sv */
// ----------------------------------------------------------------------------
// lsv_pkg
// Shared constants, codes and types of the looping sample voice.
// ----------------------------------------------------------------------------
`default_nettype none

package lsv_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 12;

    localparam int CMD_W   = 3;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int SUM_W   = 20;
    localparam int VALUE_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STEP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_VOLUME = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POS    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

    localparam logic [CIDX_W-1:0] REG_SAMPLE_LENGTH = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LOOP_START    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LOOP_LENGTH   = 2'd2;
    localparam logic [CIDX_W-1:0] REG_OVERSAMPLE    = 2'd3;

    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_PLAY = 2'd1;
    localparam logic [1:0] MODE_LOOP = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/lsv_sample_mem.sv */
// ----------------------------------------------------------------------------
// lsv_sample_mem
// Sample word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsv_sample_mem #(
    parameter int ADDR_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [7:0]           wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic signed [7:0]         rd_data
);

    logic [7:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= $signed(mem[rd_addr]);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lsv_divider.sv */
// ----------------------------------------------------------------------------
// lsv_divider
// Restoring divider, one quotient bit per cycle; shared by the loop wrap
// (remainder) and the oversample average (quotient).
// ----------------------------------------------------------------------------
`default_nettype none

module lsv_divider #(
    parameter int DIV_W = 20
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [DIV_W-1:0]        dividend,
    input  wire logic [15:0]             divisor,
    output logic [DIV_W-1:0]             quotient,
    output logic [15:0]                  remainder,
    output lsv_pkg::div_stat_t           stat
);
    import lsv_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[15:0] : trial[15:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* rtl/core/looping_sample_voice.sv */
// ----------------------------------------------------------------------------
// looping_sample_voice
// One wavetable playback voice with optional loop, driven by command beats.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes command beats (s_tuser = command). Load, play,
// set step, set volume and set position give no result.
// A tick beat runs a sequencer that reuses one multiplier and one divider and
// returns one m_ beat (value, pending shift, playing flag).
// On a tick, nearest mode runs oversample sub-steps, linear mode one step;
// a sub-step whose pointer must be folded into the loop waits on the divider,
// play first entering the loop takes an extra pass through pointer locate,
// and averaging by factors other than 1, 2, 4 waits on the divider as well.
// Accept, wrap-up and finish states frame this work. s_tready is low while
// a tick is being worked.
// Configuration beats on cfg_ are always taken and must only come when idle.
// Reset (aresetn low, synchronous) turns the voice off and clears step, gain
// and pointer; sample memory is undefined until loaded.
// A stalled m_ beat holds; further commands are still taken, and a finished
// tick waits in its finish cycle for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module looping_sample_voice #(
    parameter int ADDR_BITS = lsv_pkg::ADDR_BITS_DEF,
    parameter int FRAC_BITS = lsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // address[15:0], sample_data[23:16], step_rate[47:24], gain[55:48]
    input  wire logic [55:0]                 s_tdata,
    // command[2:0]
    input  wire logic [lsv_pkg::CMD_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // mixed_value[31:0], extra_shift[33:32], playing[34], zero pad[39:35]
    output logic [39:0]                      m_tdata,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lsv_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [lsv_pkg::CFG_W-1:0]   cfg_data
);
    import lsv_pkg::*;

    localparam int PTR_W  = ADDR_BITS + FRAC_BITS;
    localparam int CMP_W  = (ADDR_BITS > 16 ? ADDR_BITS : 16) + FRAC_BITS;
    localparam int LCMP_W = ADDR_BITS > 16 ? ADDR_BITS : 16;
    localparam int DIV_W  = ADDR_BITS > SUM_W ? ADDR_BITS : SUM_W;
    localparam int ACC_W  = FRAC_BITS + 9;
    localparam int MB_W   = FRAC_BITS + 2;
    localparam int PROD_W = ACC_W + MB_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOC  = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_NEAR = 4'd4;
    localparam logic [3:0] S_RD1  = 4'd5;
    localparam logic [3:0] S_LA   = 4'd6;
    localparam logic [3:0] S_LB   = 4'd7;
    localparam logic [3:0] S_LC   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;
    localparam logic [3:0] S_AVG  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    // input fields
    logic [CMD_W-1:0] in_cmd;
    logic [15:0]      in_addr;
    logic [7:0]       in_sample;
    logic [23:0]      in_step;
    logic [7:0]       in_gain;
    logic             s_fire;

    assign in_cmd    = s_tuser;
    assign in_addr   = s_tdata[15:0];
    assign in_sample = s_tdata[23:16];
    assign in_step   = s_tdata[47:24];
    assign in_gain   = s_tdata[55:48];
    assign s_fire    = s_tvalid && s_tready;

    logic [3:0]              state_reg, state_next;
    logic [1:0]              mode_reg, mode_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [23:0]             step_reg, step_next;
    logic [7:0]              gain_reg, gain_next;
    logic [15:0]             sample_length_reg;
    logic [15:0]             loop_start_reg;
    logic [15:0]             loop_length_reg;
    logic [3:0]              oversample_reg;
    logic [ADDR_BITS-1:0]    base_reg, base_next;
    logic [3:0]              sub_reg, sub_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [7:0]       s0_reg, s0_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0]      value_reg, value_next;
    logic                    m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]      m_value_reg, m_value_next;
    logic [1:0]              m_shift_reg, m_shift_next;
    logic                    m_play_reg, m_play_next;

    // memory, divider, multiplier
    logic                    mem_we;
    logic                    mem_re;
    logic [ADDR_BITS-1:0]    mem_raddr;
    logic signed [7:0]       mem_rdata;
    logic                    div_start;
    logic [DIV_W-1:0]        div_dividend;
    logic [15:0]             div_divisor;
    logic [DIV_W-1:0]        div_quo;
    logic [15:0]             div_rem;
    div_stat_t               div_stat;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] product;

    // pointer helpers
    logic [FRAC_BITS-1:0]    frac;
    logic [ADDR_BITS-1:0]    ptr_int;
    logic [CMP_W-1:0]        flen;
    logic [PTR_W-1:0]        pos_ptr;
    logic [FRAC_BITS:0]      unit_minus;
    logic [SUM_W-1:0]        sum_mag;
    logic [VALUE_W-1:0]      quo_ext;
    logic [4:0]              sub_inc;

    assign frac       = ptr_reg[FRAC_BITS-1:0];
    assign ptr_int    = ptr_reg[PTR_W-1:FRAC_BITS];
    assign flen       = CMP_W'({sample_length_reg, {FRAC_BITS{1'b0}}});
    assign pos_ptr    = {ADDR_BITS'(in_addr), {FRAC_BITS{1'b0}}};
    assign unit_minus = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quo_ext    = VALUE_W'(div_quo);
    assign sub_inc    = {1'b0, sub_reg} + 5'd1;

    assign product = mul_a * mul_b;

    assign mem_we    = s_fire && (in_cmd == CMD_LOAD);
    assign mem_re    = (state_reg == S_RD0) || (state_reg == S_RD1);
    assign mem_raddr = base_reg + ptr_int + ((state_reg == S_RD1) ? ADDR_BITS'(1) : '0);

    lsv_sample_mem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (ADDR_BITS'(in_addr)),
        .wr_data (in_sample),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    lsv_divider #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    always_comb begin
        unique case (state_reg)
            S_LA: begin
                mul_a = ACC_W'(s0_reg);
                mul_b = $signed({1'b0, unit_minus});
            end
            S_LB: begin
                mul_a = ACC_W'(mem_rdata);
                mul_b = $signed({2'b00, frac});
            end
            S_LC: begin
                mul_a = acc_reg;
                mul_b = MB_W'($signed({1'b0, gain_reg}));
            end
            default: begin
                mul_a = ACC_W'(mem_rdata);
                mul_b = MB_W'($signed({1'b0, gain_reg}));
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        ptr_next     = ptr_reg;
        step_next    = step_reg;
        gain_next    = gain_reg;
        base_next    = base_reg;
        sub_next     = sub_reg;
        sum_next     = sum_reg;
        s0_next      = s0_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_value_next = m_value_reg;
        m_shift_next = m_shift_reg;
        m_play_next  = m_play_reg;
        div_start    = 1'b0;
        div_dividend = DIV_W'(ptr_int);
        div_divisor  = loop_length_reg;
        s_tready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    priority case (in_cmd)
                        CMD_PLAY: begin
                            ptr_next  = '0;
                            step_next = in_step;
                            gain_next = in_gain;
                            mode_next = MODE_PLAY;
                        end
                        CMD_STEP:   step_next = in_step;
                        CMD_VOLUME: gain_next = in_gain;
                        CMD_POS: begin
                            ptr_next  = pos_ptr;
                            mode_next = (CMP_W'(pos_ptr) >= flen) ? MODE_OFF : MODE_PLAY;
                        end
                        CMD_TICK: begin
                            sub_next   = '0;
                            sum_next   = '0;
                            value_next = '0;
                            state_next = S_LOC;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOC: begin
                priority if (mode_reg == MODE_PLAY) begin
                    if (CMP_W'(ptr_reg) < flen) begin
                        base_next  = '0;
                        state_next = S_RD0;
                    end else if (loop_length_reg == '0) begin
                        mode_next  = MODE_OFF;
                        state_next = S_DONE;
                    end else begin
                        mode_next = MODE_LOOP;
                        ptr_next  = ptr_reg - PTR_W'(flen);
                    end
                end else if (mode_reg == MODE_LOOP) begin
                    if (loop_length_reg == '0) begin
                        mode_next  = MODE_OFF;
                        state_next = S_DONE;
                    end else if (LCMP_W'(ptr_int) < LCMP_W'(loop_length_reg)) begin
                        base_next  = ADDR_BITS'(loop_start_reg);
                        state_next = S_RD0;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_MOD: begin
                if (div_stat.done) begin
                    ptr_next   = {ADDR_BITS'(div_rem), frac};
                    base_next  = ADDR_BITS'(loop_start_reg);
                    state_next = S_RD0;
                end
            end
            S_RD0: begin
                state_next = (oversample_reg == '0) ? S_RD1 : S_NEAR;
            end
            S_NEAR: begin
                sum_next = sum_reg + SUM_W'(product);
                ptr_next = ptr_reg + PTR_W'(step_reg);
                sub_next = sub_inc[3:0];
                state_next = (sub_inc < {1'b0, oversample_reg}) ? S_LOC : S_DONE;
            end
            S_RD1: begin
                s0_next    = mem_rdata;
                state_next = S_LA;
            end
            S_LA: begin
                prod_next  = ACC_W'(product);
                state_next = S_LB;
            end
            S_LB: begin
                acc_next   = prod_reg + ACC_W'(product);
                state_next = S_LC;
            end
            S_LC: begin
                value_next = VALUE_W'(product);
                ptr_next   = ptr_reg + PTR_W'(step_reg);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (oversample_reg == 4'd0) begin
                    state_next = S_FIN;
                end else if (oversample_reg == 4'd1 || oversample_reg == 4'd2 ||
                             oversample_reg == 4'd4) begin
                    value_next = VALUE_W'(sum_reg);
                    state_next = S_FIN;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_mag);
                    div_divisor  = {12'd0, oversample_reg};
                    state_next   = S_AVG;
                end
            end
            S_AVG: begin
                div_divisor = {12'd0, oversample_reg};
                if (div_stat.done) begin
                    value_next = sum_reg[SUM_W-1] ? -quo_ext : quo_ext;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = value_reg;
                    m_shift_next = (oversample_reg == 4'd2) ? 2'd1 :
                                   (oversample_reg == 4'd4) ? 2'd2 : 2'd0;
                    m_play_next  = (mode_reg == MODE_PLAY) || (mode_reg == MODE_LOOP);
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            mode_reg          <= MODE_OFF;
            ptr_reg           <= '0;
            step_reg          <= '0;
            gain_reg          <= '0;
            m_valid_reg       <= 1'b0;
            sample_length_reg <= 16'd1;
            loop_start_reg    <= '0;
            loop_length_reg   <= '0;
            oversample_reg    <= 4'd1;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            ptr_reg     <= ptr_next;
            step_reg    <= step_next;
            gain_reg    <= gain_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_SAMPLE_LENGTH: sample_length_reg <= cfg_data;
                    REG_LOOP_START:    loop_start_reg    <= cfg_data;
                    REG_LOOP_LENGTH:   loop_length_reg   <= cfg_data;
                    REG_OVERSAMPLE:    oversample_reg    <= cfg_data[3:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        sub_reg     <= sub_next;
        sum_reg     <= sum_next;
        s0_reg      <= s0_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        value_reg   <= value_next;
        m_value_reg <= m_value_next;
        m_shift_reg <= m_shift_next;
        m_play_reg  <= m_play_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {5'd0, m_play_reg, m_shift_reg, m_value_reg};

`include "looping_sample_voice_assert.svh"

    `LSV_ASSERT_IMPL(a_div_owner, div_stat.busy, (state_reg == S_MOD || state_reg == S_AVG), "divider busy outside a wait state")
    `LSV_ASSERT_IMPL(a_out_from_fin, $rose(m_valid_reg), ($past(state_reg) == S_FIN), "result beat raised outside finish")
    `LSV_ASSERT_NEXT(a_sub_bound, (state_reg == S_NEAR), (sub_reg <= oversample_reg), "sub-step count ran past oversample")

endmodule

`default_nettype wire

/* verif/lsv_checker.sv */
// ----------------------------------------------------------------------------
// lsv_checker
// Watches the command, config and result channels of the looping sample
// voice, predicts each tick result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module lsv_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [55:0]  s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output int                fail_count,
    output int                pending,
    output int                ticks_seen
);
    import lsv_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  shift;
        logic        playing;
    } tick_out_t;

    logic signed [7:0] wave_mem [0:65535];
    logic [27:0] ptr;
    logic [1:0]  mode;
    logic [23:0] step;
    logic [7:0]  gain;
    logic [15:0] slen, lstart, llen;
    logic [3:0]  osr;
    tick_out_t   tick_q[$];

    function automatic bit seek_base(output logic [15:0] base);
        logic [27:0] flen;
        logic [27:0] wlen;
        base = '0;
        if (mode == MODE_PLAY) begin
            flen = {slen, 12'd0};
            if (ptr < flen) return 1;
            if (llen == 0) begin
                mode = MODE_OFF;
                return 0;
            end
            mode = MODE_LOOP;
            ptr = ptr - flen;
        end
        if (mode == MODE_LOOP) begin
            wlen = {llen, 12'd0};
            if (llen == 0) begin
                mode = MODE_OFF;
                return 0;
            end
            ptr = ptr % wlen;
            base = lstart;
            return 1;
        end
        return 0;
    endfunction

    function automatic tick_out_t run_tick();
        tick_out_t r;
        logic [15:0] base, idx;
        longint sum, s0, s1, fr;
        sum = 0;
        r.shift = 2'd0;
        if (osr == 0) begin
            if (seek_base(base)) begin
                idx = base + ptr[27:12];
                fr = ptr[11:0];
                s0 = wave_mem[idx];
                s1 = wave_mem[16'(idx + 16'd1)];
                sum = (s0 * (4096 - fr) + s1 * fr) * longint'(gain);
                ptr = ptr + 28'(step);
            end
        end else begin
            for (int k = 0; k < osr; k++) begin
                if (seek_base(base)) begin
                    idx = base + ptr[27:12];
                    sum += longint'(wave_mem[idx]) * longint'(gain);
                    ptr = ptr + 28'(step);
                end
            end
            if (osr == 2) r.shift = 2'd1;
            else if (osr == 4) r.shift = 2'd2;
            else if (osr != 1) sum = sum / longint'(osr);
        end
        r.value = sum[31:0];
        r.playing = (mode == MODE_PLAY || mode == MODE_LOOP);
        return r;
    endfunction

    always @(posedge aclk) begin
        tick_out_t e, got;
        int errs;
        errs = 0;
        if (!aresetn) begin
            ptr = '0; mode = MODE_OFF; step = '0; gain = '0;
            slen = 16'd1; lstart = '0; llen = '0; osr = 4'd1;
            tick_q.delete();
            fail_count <= 0;
            ticks_seen <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SAMPLE_LENGTH: slen = cfg_data;
                    REG_LOOP_START:    lstart = cfg_data;
                    REG_LOOP_LENGTH:   llen = cfg_data;
                    REG_OVERSAMPLE:    osr = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    CMD_LOAD:   wave_mem[s_tdata[15:0]] = s_tdata[23:16];
                    CMD_PLAY: begin
                        ptr = '0; step = s_tdata[47:24]; gain = s_tdata[55:48];
                        mode = MODE_PLAY;
                    end
                    CMD_STEP:   step = s_tdata[47:24];
                    CMD_VOLUME: gain = s_tdata[55:48];
                    CMD_POS: begin
                        ptr = {s_tdata[15:0], 12'd0};
                        mode = (ptr >= {slen, 12'd0}) ? MODE_OFF : MODE_PLAY;
                    end
                    CMD_TICK:   tick_q.push_back(run_tick());
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.value   = m_tdata[31:0];
                got.shift   = m_tdata[33:32];
                got.playing = m_tdata[34];
                ticks_seen <= ticks_seen + 1;
                if (tick_q.size() == 0) begin
                    $error("result beat with none expected");
                    errs++;
                end else begin
                    e = tick_q.pop_front();
                    if (got.value !== e.value) begin
                        $error("mixed_value exp %0d got %0d",
                               $signed(e.value), $signed(got.value));
                        errs++;
                    end
                    if (got.shift !== e.shift) begin
                        $error("extra_shift exp %0d got %0d", e.shift, got.shift);
                        errs++;
                    end
                    if (got.playing !== e.playing) begin
                        $error("playing exp %0d got %0d", e.playing, got.playing);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= tick_q.size();
        end
    end
endmodule

`default_nettype wire

/* verif/tb_looping_sample_voice.sv */
// ----------------------------------------------------------------------------
// tb_looping_sample_voice
// Drives loads, play and tick command streams through several register
// settings and idle/stall phases; a checker predicts and compares ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_looping_sample_voice;
    import lsv_pkg::*;

    localparam int WATCHDOG = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending, ticks_seen;
    int          idle_pct = 0, stall_pct = 0, quiet = 0, loads = 0;
    logic [15:0] cur_len = 16'd1, cur_lstart = '0;

    always #6 aclk = ~aclk;

    looping_sample_voice uut (.*);

    lsv_checker chk (.*);

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(input logic [2:0] cmd, input logic [15:0] a,
                        input logic [7:0] d, input logic [23:0] r, input logic [7:0] g);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {g, r, d, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic setup(input logic [15:0] len, input logic [15:0] ls,
                         input logic [15:0] ll, input logic [3:0] os);
        drain();
        write_reg(REG_SAMPLE_LENGTH, len);
        write_reg(REG_LOOP_START, ls);
        write_reg(REG_LOOP_LENGTH, ll);
        write_reg(REG_OVERSAMPLE, {12'd0, os});
        cfg_valid <= 1'b0;
        cur_len = len;
        cur_lstart = ls;
    endtask

    // fill every word that a tick can reach: sample body plus one past it
    task automatic fill(input logic [15:0] a, input int n, input bit extreme);
        logic [7:0] d;
        for (int i = 0; i < n; i++) begin
            d = extreme ? ((i % 2) ? 8'h80 : 8'h7f) : 8'($urandom);
            send(CMD_LOAD, 16'(a + i), d, 24'($urandom), 8'($urandom));
            loads++;
        end
    endtask

    task automatic rand_cmd();
        int k;
        logic [23:0] r;
        k = $urandom_range(99);
        r = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(12000));
        if (k < 60)      send(CMD_TICK, 16'($urandom), 8'($urandom), 24'($urandom), 8'($urandom));
        else if (k < 68) send(CMD_PLAY, 16'($urandom), 8'($urandom), r, 8'($urandom));
        else if (k < 75) send(CMD_STEP, 16'($urandom), 8'($urandom), r, 8'($urandom));
        else if (k < 82) send(CMD_VOLUME, 16'($urandom), 8'($urandom), r, 8'($urandom));
        else if (k < 90) send(CMD_POS, 16'($urandom_range(cur_len + 2)), 8'($urandom), r,
                              8'($urandom));
        else if (k < 94) send(3'($urandom_range(6, 7)), 16'($urandom), 8'($urandom),
                              24'($urandom), 8'($urandom));
        else begin
            send(CMD_LOAD, 16'($urandom_range(cur_len)), 8'($urandom), 24'($urandom),
                 8'($urandom));
        end
    endtask

    initial begin
        int lens [6] = '{16'd1, 16'd8, 16'd16, 16'd24, 16'd12, 16'd20};
        int oss  [6] = '{0, 1, 2, 4, 3, 15};
        int ph;
        logic [15:0] ll;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extreme words, full-scale gain and step, no loop then loop
        setup(16'd4, 16'd0, 16'd0, 4'd1);
        fill(16'd0, 6, 1);
        send(CMD_PLAY, 16'hffff, 8'h00, 24'h000800, 8'hff);
        repeat (4) send(CMD_TICK, '0, '0, '0, '0);
        send(3'd6, '0, '0, '0, '0);
        send(3'd7, '0, '0, '0, '0);
        setup(16'd4, 16'hffff, 16'd1, 4'd0);
        send(CMD_LOAD, 16'hffff, 8'h80, '0, '0);
        send(CMD_PLAY, '0, '0, 24'hffffff, 8'hff);
        repeat (3) send(CMD_TICK, '0, '0, '0, '0);
        send(CMD_POS, 16'hffff, '0, '0, '0);
        send(CMD_TICK, '0, '0, '0, '0);
        send(CMD_POS, 16'd2, '0, '0, '0);
        send(CMD_STEP, '0, '0, 24'h001800, '0);
        send(CMD_VOLUME, '0, '0, '0, 8'h80);
        repeat (3) send(CMD_TICK, '0, '0, '0, '0);
        // loop cleared while looping
        setup(16'd4, 16'hffff, 16'd0, 4'd5);
        send(CMD_TICK, '0, '0, '0, '0);
        setup(16'hffff, 16'd0, 16'hffff, 4'd15);
        send(CMD_TICK, '0, '0, '0, '0);

        for (ph = 0; ph < 24; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            ll = 16'($urandom_range(lens[ph % 6]));
            setup(16'(lens[ph % 6]), 16'($urandom_range(40)), ll, 4'(oss[ph % 6]));
            // loaded region covers sample body and loop region, one past each
            if (ph % 6 == 0) fill(16'd0, 65, ph == 0);
            for (int i = 0; i < 36; i++) begin
                rand_cmd();
                if (i == 20 && ph == 5) begin
                    drain();
                end
            end
        end

        drain();
        $display("Ran %0d ticks and %0d loads over 24 register settings, all idle phases.",
                 ticks_seen, loads);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/lsv_pkg.sv
rtl/core/lsv_sample_mem.sv
rtl/core/lsv_divider.sv
rtl/core/looping_sample_voice.sv
verif/lsv_checker.sv
verif/tb_looping_sample_voice.sv
